>>> rtl/core/udpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package udpf_pkg;

    // Frame field constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  MIN_IP_FRAME   = 8'd34;
    localparam logic [7:0]  NUM_QUEUES     = 8'd64;

    // Byte offsets inside the frame
    localparam logic [6:0] OFF_FIRST   = 7'd0;
    localparam logic [6:0] OFF_ETYPE_HI = 7'd12;
    localparam logic [6:0] OFF_ETYPE_LO = 7'd13;
    localparam logic [6:0] OFF_IHL     = 7'd14;
    localparam logic [6:0] OFF_PROTO   = 7'd23;
    localparam logic [6:0] OFF_PORT    = 7'd16;
    localparam logic [6:0] OFF_MAX     = 7'd127;
    localparam logic [7:0] LEN_HDR_BASE = 8'd22;

    // Configuration register indexes
    localparam logic REG_MATCH_PORT  = 1'b0;
    localparam logic REG_SOCKET_MASK = 1'b1;

    typedef struct packed {
        logic       verdict;
        logic [7:0] target_queue;
    } verdict_t;

endpackage

`default_nettype wire

>>> rtl/core/udpf_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-frame field capture; gives the verdict of the beat being accepted.
module udpf_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              beat_accept,
    input  wire logic [7:0]        frame_byte,
    input  wire logic [7:0]        rx_queue,
    input  wire logic              last_byte,
    input  wire logic [15:0]       match_port,
    input  wire logic [63:0]       socket_mask,
    output udpf_pkg::verdict_t     result
);

    logic [6:0]  offset_reg, offset_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  hwords_reg, hwords_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] dport_reg, dport_next;
    logic [7:0]  fqueue_reg, fqueue_next;

    logic [6:0]  port_pos;
    logic [7:0]  frame_len;
    logic [7:0]  min_len;
    logic        queue_ok;
    logic        redirect;

    // port position uses the header length seen before this byte
    assign port_pos = udpf_pkg::OFF_PORT + {1'b0, hwords_reg, 2'b00};

    always_comb begin
        fqueue_next = (offset_reg == udpf_pkg::OFF_FIRST) ? rx_queue : fqueue_reg;
        etype_next  = etype_reg;
        if (offset_reg == udpf_pkg::OFF_ETYPE_HI) begin
            etype_next[15:8] = frame_byte;
        end
        if (offset_reg == udpf_pkg::OFF_ETYPE_LO) begin
            etype_next[7:0] = frame_byte;
        end
        hwords_next = (offset_reg == udpf_pkg::OFF_IHL) ? frame_byte[3:0] : hwords_reg;
        proto_next  = (offset_reg == udpf_pkg::OFF_PROTO) ? frame_byte : proto_reg;
        dport_next  = dport_reg;
        if (offset_reg != udpf_pkg::OFF_IHL && offset_reg == port_pos) begin
            dport_next[15:8] = frame_byte;
        end
        if (offset_reg != udpf_pkg::OFF_IHL && offset_reg == port_pos + 7'd1) begin
            dport_next[7:0] = frame_byte;
        end
        offset_next = (offset_reg == udpf_pkg::OFF_MAX) ? udpf_pkg::OFF_MAX
                                                        : offset_reg + 7'd1;
    end

    assign frame_len = {1'b0, offset_reg} + 8'd1;
    assign min_len   = udpf_pkg::LEN_HDR_BASE + {2'b00, hwords_next, 2'b00};
    assign queue_ok  = (fqueue_next < udpf_pkg::NUM_QUEUES) && (fqueue_next[7:6] == 2'b00)
                       && socket_mask[fqueue_next[5:0]];

    assign redirect = (etype_next == udpf_pkg::ETHERTYPE_IPV4)
                   && (proto_next == udpf_pkg::PROTO_UDP)
                   && (frame_len >= udpf_pkg::MIN_IP_FRAME)
                   && (frame_len >= min_len)
                   && (dport_next == match_port)
                   && queue_ok;

    assign result.verdict      = redirect;
    assign result.target_queue = redirect ? fqueue_next : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_accept && last_byte)) begin
            offset_reg <= '0;
            etype_reg  <= '0;
            hwords_reg <= '0;
            proto_reg  <= '0;
            dport_reg  <= '0;
            fqueue_reg <= '0;
        end else if (beat_accept) begin
            offset_reg <= offset_next;
            etype_reg  <= etype_next;
            hwords_reg <= hwords_next;
            proto_reg  <= proto_next;
            dport_reg  <= dport_next;
            fqueue_reg <= fqueue_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/udp_port_ingress_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// UDP destination port ingress filter.
// Slave stream: one frame byte per beat in tdata, the receive queue in tuser
// (sampled on the first byte of a frame), tlast on the final byte.
// Master stream: one beat per frame, issued for the tlast beat only; tuser
// carries the verdict (1 = redirect to the fast-path socket on that queue),
// tdata the target queue (zero on pass).
// Throughput: one byte per cycle while s_axis_tready is high, across frame
// boundaries; the field capture and verdict logic sit between the input beat
// and a result register, so the frame state is updated every accepted beat.
// Output: the verdict of the tlast beat goes into the result register, or
// into the skid slot while the result register waits on m_axis_tready.
// Stall: a result register plus a one-beat skid slot. s_axis_tready drops
// only when both hold a verdict, so bytes keep flowing while one verdict
// waits to be taken.
// Reset (aresetn low, synchronous): frame state returns to start-of-frame,
// both config registers clear, and both result slots empty.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 match port,
// 1 socket mask); write only while the block is idle.
module udp_port_ingress_filter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  wire logic [7:0]  s_axis_tuser,   // [7:0] rx_queue
    input  wire logic        s_axis_tlast,   // last_byte
    // master stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // [7:0] target_queue
    output      logic [0:0]  m_axis_tuser,   // [0] verdict
    // config write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    logic [15:0] match_port_reg;
    logic [63:0] socket_mask_reg;

    udpf_pkg::verdict_t beat_result;
    udpf_pkg::verdict_t out_reg;
    udpf_pkg::verdict_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    logic s_fire;
    logic new_result;

    assign s_axis_tready = !skid_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign new_result    = s_fire && s_axis_tlast;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg  <= '0;
            socket_mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                udpf_pkg::REG_MATCH_PORT:  match_port_reg  <= cfg_wdata[15:0];
                udpf_pkg::REG_SOCKET_MASK: socket_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    udpf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (s_fire),
        .frame_byte  (s_axis_tdata),
        .rx_queue    (s_axis_tuser),
        .last_byte   (s_axis_tlast),
        .match_port  (match_port_reg),
        .socket_mask (socket_mask_reg),
        .result      (beat_result)
    );

    // result register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= new_result;
            end
        end else if (new_result) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_axis_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : beat_result;
        end else if (new_result) begin
            skid_reg <= beat_result;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.target_queue;
    assign m_axis_tuser[0] = out_reg.verdict;

    // skid slot only holds a beat behind a valid output beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a verdict while the output is empty");

    // skid fills only when the output stalled with a tlast beat arriving
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready && new_result))
        else $error("skid filled without a stall");

    // a pass verdict never names a queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("pass verdict carries a nonzero queue");

    // a tlast beat accepted with an empty output shows up next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (new_result && !out_valid_reg) |=> out_valid_reg)
        else $error("verdict lost");

endmodule

`default_nettype wire
